### hw/rtl/segment_intersection_test_unit_macros.svh
// Assertion macros for the segment intersection test unit.
// The asserting module supplies clk and rst.
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("segment intersection unit: assertion failed");
`define SIT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("segment intersection unit: assertion failed");
`else
`define SIT_ASSERT(lbl, prop)
`define SIT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### hw/rtl/sit_pkg.sv
`timescale 1ns / 1ps
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  // Sign of a cross product: both clear means positive.
  typedef struct packed {
    logic neg;
    logic zero;
  } orient_t;

endpackage

### hw/rtl/sit_cross.sv
`timescale 1ns / 1ps
// Three-stage orientation of point c against the line a -> b:
// differences, products, then subtract and sign.
module sit_cross import sit_pkg::*; (
  input  logic    clk,
  input  coord_t  a_x,
  input  coord_t  a_y,
  input  coord_t  b_x,
  input  coord_t  b_y,
  input  coord_t  c_x,
  input  coord_t  c_y,
  output orient_t sgn
);

  diff_t  dbx, dby, dcx, dcy;
  prod_t  p_left, p_right;
  cross_t cp;

  always_ff @(posedge clk) begin
    dbx <= diff_t'(b_x) - diff_t'(a_x);
    dby <= diff_t'(b_y) - diff_t'(a_y);
    dcx <= diff_t'(c_x) - diff_t'(a_x);
    dcy <= diff_t'(c_y) - diff_t'(a_y);
  end

  always_ff @(posedge clk) begin
    p_left  <= dbx * dcy;
    p_right <= dcx * dby;
  end

  assign cp = cross_t'(p_left) - cross_t'(p_right);

  always_ff @(posedge clk) begin
    sgn.neg  <= cp[CROSS_WIDTH-1];
    sgn.zero <= (cp == '0);
  end

endmodule

### hw/rtl/segment_intersection_test_unit.sv
// Segment intersection test: each accepted pair moves through the valid registers v1, v2, v3 and then done.
// Throughput one transaction per cycle; busy is low whenever rst is low.
// The receiver cannot stall: each result shows for exactly one cycle with done.
// Reset (synchronous, active high) empties the pipeline; start is ignored during it.
`timescale 1ns / 1ps
`include "segment_intersection_test_unit_macros.svh"
module segment_intersection_test_unit import sit_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  coord_t first_start_x,
  input  coord_t first_start_y,
  input  coord_t first_end_x,
  input  coord_t first_end_y,
  input  coord_t second_start_x,
  input  coord_t second_start_y,
  input  coord_t second_end_x,
  input  coord_t second_end_y,
  output logic   done,
  output logic   intersects,
  output logic   collinear_case
);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Lexicographic a <= b: x first, y breaks the tie.
  function automatic logic lex_le(input point_t a, input point_t b);
    logic r;
    if ($signed(a.x) == $signed(b.x)) begin
      r = ($signed(a.y) <= $signed(b.y));
    end else begin
      r = ($signed(a.x) <= $signed(b.x));
    end
    return r;
  endfunction

  logic    accept;
  logic    v1, v2, v3;
  point_t  fs, fe, ss, se;
  point_t  a_lo, a_hi, b_lo, b_hi;
  logic    overlap2, overlap3;
  orient_t o_fs, o_fe, o_ss, o_se;
  logic    zero_a, zero_b, nonpos_a, nonpos_b, col, hit;

  // The pipeline never stalls, so only reset holds the port off.
  assign busy   = rst;
  assign accept = start && !busy;

  assign fs = '{x: first_start_x,  y: first_start_y};
  assign fe = '{x: first_end_x,    y: first_end_y};
  assign ss = '{x: second_start_x, y: second_start_y};
  assign se = '{x: second_end_x,   y: second_end_y};

  // Valid bits advance one stage per cycle alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Orientation of each segment's endpoints against the other segment's line.
  sit_cross u_cross_fs (
    .clk(clk), .a_x(second_start_x), .a_y(second_start_y),
    .b_x(second_end_x), .b_y(second_end_y),
    .c_x(first_start_x), .c_y(first_start_y), .sgn(o_fs)
  );
  sit_cross u_cross_fe (
    .clk(clk), .a_x(second_start_x), .a_y(second_start_y),
    .b_x(second_end_x), .b_y(second_end_y),
    .c_x(first_end_x), .c_y(first_end_y), .sgn(o_fe)
  );
  sit_cross u_cross_ss (
    .clk(clk), .a_x(first_start_x), .a_y(first_start_y),
    .b_x(first_end_x), .b_y(first_end_y),
    .c_x(second_start_x), .c_y(second_start_y), .sgn(o_ss)
  );
  sit_cross u_cross_se (
    .clk(clk), .a_x(first_start_x), .a_y(first_start_y),
    .b_x(first_end_x), .b_y(first_end_y),
    .c_x(second_end_x), .c_y(second_end_y), .sgn(o_se)
  );

  // Collinear path, stage 1: order each segment's endpoints.
  // A swap on equal endpoints is harmless, so swap whenever end <= start.
  always_ff @(posedge clk) begin
    if (lex_le(fe, fs)) begin
      a_lo <= fe;
      a_hi <= fs;
    end else begin
      a_lo <= fs;
      a_hi <= fe;
    end
    if (lex_le(se, ss)) begin
      b_lo <= se;
      b_hi <= ss;
    end else begin
      b_lo <= ss;
      b_hi <= se;
    end
  end

  // Stage 2: check that the ordered extents overlap; stage 3 holds the flag
  // until the orientation signs arrive.
  always_ff @(posedge clk) begin
    overlap2 <= lex_le(b_lo, a_hi) && lex_le(a_lo, b_hi);
    overlap3 <= overlap2;
  end

  // Product of two signs is zero when either is zero, and non-positive when
  // either is zero or the two signs differ.
  assign zero_a   = o_ss.zero || o_se.zero;
  assign zero_b   = o_fs.zero || o_fe.zero;
  assign nonpos_a = zero_a || (o_ss.neg != o_se.neg);
  assign nonpos_b = zero_b || (o_fs.neg != o_fe.neg);
  assign col      = zero_a && zero_b;
  assign hit      = col ? overlap3 : (nonpos_a && nonpos_b);

  // Stage 4: result register; drop the flags to zero outside the done cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      intersects     <= 1'b0;
      collinear_case <= 1'b0;
    end else begin
      intersects     <= v3 && hit;
      collinear_case <= v3 && col;
    end
  end

  `SIT_ASSERT(a_accept_to_done, accept |-> ##4 done)
  `SIT_ASSERT(a_idle_no_done, !accept |-> ##4 !done)
  `SIT_ASSERT_ALWAYS(a_flags_only_with_done, !done |-> (!intersects && !collinear_case))
  `SIT_ASSERT(a_reset_empties, $fell(rst) |-> !done && !v3)

endmodule

### test/tb_segment_intersection_test_unit.sv
`timescale 1ns / 1ps
module tb_segment_intersection_test_unit;
  import sit_pkg::*;

  localparam int PAIR_COUNT   = 1800;
  localparam int IDLE_PCT     = 38;
  // Pipeline is 4 deep; DRAIN_CYCLES covers it after the last verdict.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // One segment pair: first segment p0-p1, second segment q0-q1.
  typedef struct packed {
    coord_t p0x, p0y, p1x, p1y;
    coord_t q0x, q0y, q1x, q1y;
  } seg_pair_t;

  typedef struct packed {
    logic hit;
    logic col;
  } verdict_t;

  // Holds the verdicts of pairs in flight and compares each done cycle
  // against the oldest one.
  class crossing_board;
    verdict_t awaited_verdicts[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Sign of (b - a) x (c - a), exact in 64 bits.
    static function int turn_sign(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
      longint cp;
      cp = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
      return (cp > 0) ? 1 : ((cp < 0) ? -1 : 0);
    endfunction

    // Lexicographic a <= b, x first, then y.
    static function bit lex_not_after(longint ax, longint ay, longint bx, longint by);
      return (ax == bx) ? (ay <= by) : (ax <= bx);
    endfunction

    static function verdict_t judge_crossing(seg_pair_t s);
      longint p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y, t;
      int side_q, side_p;
      verdict_t v;
      p0x = longint'($signed(s.p0x)); p0y = longint'($signed(s.p0y));
      p1x = longint'($signed(s.p1x)); p1y = longint'($signed(s.p1y));
      q0x = longint'($signed(s.q0x)); q0y = longint'($signed(s.q0y));
      q1x = longint'($signed(s.q1x)); q1y = longint'($signed(s.q1y));
      side_q = turn_sign(p0x, p0y, p1x, p1y, q0x, q0y) *
               turn_sign(p0x, p0y, p1x, p1y, q1x, q1y);
      side_p = turn_sign(q0x, q0y, q1x, q1y, p0x, p0y) *
               turn_sign(q0x, q0y, q1x, q1y, p1x, p1y);
      v.col = (side_q == 0) && (side_p == 0);
      if (v.col) begin
        // Order each segment's endpoints, then test extent overlap.
        if (lex_not_after(p1x, p1y, p0x, p0y)) begin
          t = p0x; p0x = p1x; p1x = t;
          t = p0y; p0y = p1y; p1y = t;
        end
        if (lex_not_after(q1x, q1y, q0x, q0y)) begin
          t = q0x; q0x = q1x; q1x = t;
          t = q0y; q0y = q1y; q1y = t;
        end
        v.hit = lex_not_after(q0x, q0y, p1x, p1y) && lex_not_after(p0x, p0y, q1x, q1y);
      end else begin
        v.hit = (side_q <= 0) && (side_p <= 0);
      end
      return v;
    endfunction

    function void note_pair(seg_pair_t s);
      awaited_verdicts.push_back(judge_crossing(s));
    endfunction

    function void check_verdict(logic hit, logic col);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        $error("done with no pair in flight: intersects=%b collinear_case=%b", hit, col);
        mismatches++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (hit !== want.hit) begin
        $error("intersects: expected %b, actual %b", want.hit, hit);
        mismatches++;
      end
      if (col !== want.col) begin
        $error("collinear_case: expected %b, actual %b", want.col, col);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  logic      done;
  logic      intersects;
  logic      collinear_case;
  seg_pair_t pair_drive;
  int        idle_pct;

  crossing_board board;

  segment_intersection_test_unit uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_start_x  (pair_drive.p0x),
    .first_start_y  (pair_drive.p0y),
    .first_end_x    (pair_drive.p1x),
    .first_end_y    (pair_drive.p1y),
    .second_start_x (pair_drive.q0x),
    .second_start_y (pair_drive.q0y),
    .second_end_x   (pair_drive.q1x),
    .second_end_y   (pair_drive.q1y),
    .done           (done),
    .intersects     (intersects),
    .collinear_case (collinear_case)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic seg_pair_t pair_of(int a, int b, int c, int d,
                                        int e, int f, int g, int h);
    seg_pair_t s;
    s.p0x = coord_t'(a); s.p0y = coord_t'(b);
    s.p1x = coord_t'(c); s.p1y = coord_t'(d);
    s.q0x = coord_t'(e); s.q0y = coord_t'(f);
    s.q1x = coord_t'(g); s.q1y = coord_t'(h);
    return s;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // Build a random pair. The mix leans on small grids and constructed lines so
  // that collinear, touching and degenerate pairs turn up often; full-range
  // pairs keep every coordinate bit toggling.
  function automatic seg_pair_t random_pair();
    int v[8];
    int pick, bx, by, dx, dy, k, t;
    pick = $urandom_range(99);
    if (pick < 30) begin
      foreach (v[k]) v[k] = int'($urandom_range(65535)) - 32768;
    end else if (pick < 50) begin
      foreach (v[k]) v[k] = int'($urandom_range(12)) - 6;
    end else if (pick < 70) begin
      // Four points on one line through a base point.
      bx = int'($urandom_range(4000)) - 2000;
      by = int'($urandom_range(4000)) - 2000;
      dx = int'($urandom_range(8)) - 4;
      dy = int'($urandom_range(8)) - 4;
      for (k = 0; k < 4; k++) begin
        t = int'($urandom_range(24)) - 12;
        v[2*k]   = bx + t * dx;
        v[2*k+1] = by + t * dy;
      end
    end else if (pick < 78) begin
      // Axis-aligned line at full range; swap axes half the time.
      t = int'($urandom_range(65535)) - 32768;
      for (k = 0; k < 4; k++) begin
        v[2*k]   = int'($urandom_range(65535)) - 32768;
        v[2*k+1] = t;
      end
      if ($urandom_range(1)) begin
        for (k = 0; k < 4; k++) begin
          t = v[2*k]; v[2*k] = v[2*k+1]; v[2*k+1] = t;
        end
      end
    end else if (pick < 86) begin
      // Shared endpoint between the two segments.
      foreach (v[k]) v[k] = ($urandom_range(1)) ? int'($urandom_range(65535)) - 32768
                                                 : int'($urandom_range(20)) - 10;
      k = 2 * $urandom_range(1);
      t = 4 + 2 * $urandom_range(1);
      v[t] = v[k];
      v[t+1] = v[k+1];
    end else if (pick < 92) begin
      // Collapse the first, the second, both or neither segment to a point.
      foreach (v[k]) v[k] = int'($urandom_range(40)) - 20;
      if ($urandom_range(2) != 0) begin v[2] = v[0]; v[3] = v[1]; end
      if ($urandom_range(2) != 0) begin v[6] = v[4]; v[7] = v[5]; end
    end else begin
      foreach (v[k]) v[k] = extreme_coord();
    end
    return pair_of(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  // Present one pair and hold it until the block takes it. Idle cycles in
  // front carry junk coordinates with start low.
  task automatic drive_pair(input seg_pair_t s);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      pair_drive <= random_pair();
      @(negedge clk);
    end
    start      <= 1'b1;
    pair_drive <= s;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sample at the rising edge: note each accepted transaction, check each
  // verdict on its done cycle.
  always @(posedge clk) begin
    if (!rst && start && !busy) board.note_pair(pair_drive);
    if (!rst && done) board.check_verdict(intersects, collinear_case);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_segment_intersection_test_unit failed");
    $finish;
  end

  initial begin
    int n;
    rst        = 1'b1;
    start      = 1'b0;
    pair_drive = '0;
    idle_pct   = IDLE_PCT;
    board      = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Proper crossing, small and at full scale.
    drive_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    drive_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    // Parallel apart, near miss, T-touch, shared endpoint.
    drive_pair(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
    drive_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 9));
    drive_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
    drive_pair(pair_of(0, 0, 4, 4, 4, 4, 9, 1));
    // Collinear: overlap, disjoint, touching with reversed endpoints.
    drive_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    drive_pair(pair_of(0, 0, 4, 0, 5, 0, 9, 0));
    drive_pair(pair_of(4, 4, 0, 0, 8, 8, 4, 4));
    // Vertical collinear, ordering falls to y.
    drive_pair(pair_of(3, 9, 3, -2, 3, 0, 3, 20));
    drive_pair(pair_of(3, -5, 3, -1, 3, 0, 3, 20));
    // Point segments: off the line but inside the lexicographic extent,
    // outside it, coincident points, distinct points.
    drive_pair(pair_of(5, 100, 5, 100, 0, 0, 10, 0));
    drive_pair(pair_of(20, 100, 20, 100, 0, 0, 10, 0));
    drive_pair(pair_of(7, -7, 7, -7, 7, -7, 7, -7));
    drive_pair(pair_of(7, -7, 7, -7, 7, -6, 7, -6));
    // Bit patterns across every coordinate.
    drive_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    drive_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
    drive_pair(pair_of(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846));
    drive_pair(pair_of(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845));
    // Extremes: collinear on the top edge, parallel edges, diagonal touch.
    drive_pair(pair_of(-32768, 32767, 32767, 32767, 0, 32767, -1, 32767));
    drive_pair(pair_of(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    drive_pair(pair_of(-32768, -32768, 0, 0, 0, 0, 32767, 32767));
    drive_pair(pair_of(32767, -32768, -32768, 32767, -32768, -32767, 32767, 32766));

    // Random pairs; one long stretch runs back to back with no idling.
    for (n = 0; n < PAIR_COUNT; n++) begin
      idle_pct = (n >= 600 && n < 1000) ? 0 : IDLE_PCT;
      drive_pair(random_pair());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain, then give the pipeline time to show any stray done.
    while (board.awaited_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("tb_segment_intersection_test_unit passed");
    else
      $display("tb_segment_intersection_test_unit failed");
    $finish;
  end

endmodule
